@@ hw/rtl/look_at_view_matrix_top_assert.svh @@
// ----------------------------------------------------------------------------
// look-at view matrix assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH

// same-cycle implication
`define LAVM_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define LAVM_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ hw/rtl/lavm_pkg.sv @@
// ----------------------------------------------------------------------------
// lavm_pkg
// shared constants and types of the look-at view matrix block
// ----------------------------------------------------------------------------
package lavm_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int COORD_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		ROW_RIGHT,
		ROW_UP,
		ROW_BACK
	} row_t;

endpackage

@@ hw/rtl/lavm_if.sv @@
// ----------------------------------------------------------------------------
// lavm interfaces
// camera input channel and matrix row output channel, valid/ready
// ----------------------------------------------------------------------------
interface lavm_in_if #(
	parameter int COORD_WIDTH = lavm_pkg::COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;
	logic signed [COORD_WIDTH-1:0] target_x;
	logic signed [COORD_WIDTH-1:0] target_y;
	logic signed [COORD_WIDTH-1:0] target_z;
	logic signed [COORD_WIDTH-1:0] upward_x;
	logic signed [COORD_WIDTH-1:0] upward_y;
	logic signed [COORD_WIDTH-1:0] upward_z;

	modport source (
		output valid, pos_x, pos_y, pos_z, target_x, target_y, target_z,
		       upward_x, upward_y, upward_z,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, pos_z, target_x, target_y, target_z,
		       upward_x, upward_y, upward_z,
		output ready
	);
endinterface

interface lavm_out_if #(
	parameter int COORD_WIDTH = lavm_pkg::COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic [1:0]                    row_index;
	logic signed [COORD_WIDTH-1:0] col_zero;
	logic signed [COORD_WIDTH-1:0] col_one;
	logic signed [COORD_WIDTH-1:0] col_two;
	logic signed [COORD_WIDTH-1:0] col_three;
	logic                          last_row;
	logic                          degenerate;

	modport source (
		output valid, row_index, col_zero, col_one, col_two, col_three, last_row,
		       degenerate,
		input  ready
	);
	modport sink (
		input  valid, row_index, col_zero, col_one, col_two, col_three, last_row,
		       degenerate,
		output ready
	);
endinterface

@@ hw/rtl/lavm_norm.sv @@
// ----------------------------------------------------------------------------
// lavm_norm
// pipelined vector normalise: squares, bit-serial square root, one quotient
// bit per stage division of each component, sideband carried alongside
// ----------------------------------------------------------------------------
module lavm_norm #(
	parameter int VW     = 33,
	parameter int FRAC   = 16,
	parameter int SIDE_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [2:0][VW-1:0]     vec_in,
	input  logic [SIDE_W-1:0]      in_side,
	output logic                   out_valid,
	output logic [2:0][FRAC+1:0]   vec_out,
	output logic [SIDE_W-1:0]      out_side
);
	import lavm_pkg::*;

	localparam int RB  = VW + 1;
	localparam int SQW = 2 * RB;
	localparam int RW  = RB + 2;
	localparam int DW  = VW + FRAC + 1;
	localparam int QW  = FRAC + 1;
	localparam int OW  = FRAC + 2;
	localparam int NS  = RB;
	localparam int ND  = FRAC + 1;

	// front: magnitudes, squares, sum
	logic                 v_s1, v_s2, v_s3;
	logic [2:0][VW-1:0]   mag_s1, mag_s2, mag_s3;
	logic [2:0]           neg_s1, neg_s2, neg_s3;
	logic [2:0][2*VW-1:0] sq_s2;
	logic [SQW-1:0]       sum_s3;
	logic [SIDE_W-1:0]    side_s1, side_s2, side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec_in[i][VW-1];
				mag_s1[i] <= vec_in[i][VW-1] ? (~vec_in[i] + 1'b1) : vec_in[i];
				sq_s2[i]  <= mag_s1[i] * mag_s1[i];
			end
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			sum_s3  <= SQW'(sq_s2[0]) + SQW'(sq_s2[1]) + SQW'(sq_s2[2]);
			side_s1 <= in_side;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
		end
	end

	// square root, one result bit per stage
	logic                 rt_v_s    [NS+1];
	logic [SQW-1:0]       rt_rad_s  [NS+1];
	logic [RW-1:0]        rt_rem_s  [NS+1];
	logic [RB-1:0]        rt_res_s  [NS+1];
	logic [2:0][VW-1:0]   rt_mag_s  [NS+1];
	logic [2:0]           rt_neg_s  [NS+1];
	logic [SIDE_W-1:0]    rt_side_s [NS+1];

	assign rt_v_s[0]    = v_s3;
	assign rt_rad_s[0]  = sum_s3;
	assign rt_rem_s[0]  = '0;
	assign rt_res_s[0]  = '0;
	assign rt_mag_s[0]  = mag_s3;
	assign rt_neg_s[0]  = neg_s3;
	assign rt_side_s[0] = side_s3;

	for (genvar k = 0; k < NS; k++) begin : g_root
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;
		logic          take;

		assign rem_sh = {rt_rem_s[k][RW-3:0], rt_rad_s[k][SQW-1 -: 2]};
		assign trial  = {rt_res_s[k], 2'b01};
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else if (en) begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[k+1]  <= take ? (rem_sh - trial) : rem_sh;
				rt_res_s[k+1]  <= {rt_res_s[k][RB-2:0], take};
				rt_rad_s[k+1]  <= rt_rad_s[k] << 2;
				rt_mag_s[k+1]  <= rt_mag_s[k];
				rt_neg_s[k+1]  <= rt_neg_s[k];
				rt_side_s[k+1] <= rt_side_s[k];
			end
		end
	end

	// restoring division, quotient bits from the top down
	logic                 dv_v_s    [ND+1];
	logic [RB-1:0]        dv_root_s [ND+1];
	logic [2:0][DW-1:0]   dv_rem_s  [ND+1];
	logic [2:0][QW-1:0]   dv_q_s    [ND+1];
	logic [2:0]           dv_neg_s  [ND+1];
	logic [SIDE_W-1:0]    dv_side_s [ND+1];

	assign dv_v_s[0]    = rt_v_s[NS];
	assign dv_root_s[0] = rt_res_s[NS];
	assign dv_q_s[0]    = '0;
	assign dv_neg_s[0]  = rt_neg_s[NS];
	assign dv_side_s[0] = rt_side_s[NS];

	for (genvar i = 0; i < 3; i++) begin : g_num
		assign dv_rem_s[0][i] = DW'(rt_mag_s[NS][i]) << FRAC;
	end

	for (genvar j = 0; j < ND; j++) begin : g_div
		localparam int B = FRAC - j;
		logic [DW-1:0] trial;
		logic [2:0]    take;

		assign trial = DW'(dv_root_s[j]) << B;
		for (genvar i = 0; i < 3; i++) begin : g_cmp
			assign take[i] = dv_rem_s[j][i] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[j+1][i] <= take[i] ? (dv_rem_s[j][i] - trial) : dv_rem_s[j][i];
					dv_q_s[j+1][i]   <= dv_q_s[j][i] | (QW'(take[i]) << B);
				end
				dv_root_s[j+1] <= dv_root_s[j];
				dv_neg_s[j+1]  <= dv_neg_s[j];
				dv_side_s[j+1] <= dv_side_s[j];
			end
		end
	end

	// zero-length vector stays zero
	logic root_zero;
	assign root_zero = dv_root_s[ND] == '0;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (root_zero) begin
				vec_out[i] = '0;
			end else if (dv_neg_s[ND][i]) begin
				vec_out[i] = ~OW'(dv_q_s[ND][i]) + 1'b1;
			end else begin
				vec_out[i] = OW'(dv_q_s[ND][i]);
			end
		end
	end

	assign out_valid = dv_v_s[ND];
	assign out_side  = dv_side_s[ND];

endmodule

@@ hw/rtl/look_at_view_matrix_top.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// right-handed look-at view matrix, three rows per camera beat
// ----------------------------------------------------------------------------
// usage:
//   camera: one beat carries position, target and up hint, signed fixed point
//   rows:   three beats per camera beat, right, true up, back direction, each
//           with its translation; last_row marks the final beat
//   position equal to target gives one beat with degenerate set, fields zero
// path: a camera beat passes s1, the back normalise, s2, s3, the right
//   normalise and s4 to s8 before its first row beat; the two square root
//   chains and their division stages make up most of that path
// throughput: the output port gives one row per cycle while rows.ready is
//   high; a new camera beat enters only when the pipeline moves, with s8
//   empty or its last row taken, so degenerate beats pass one per cycle
// reset: all valid bits clear, the pipeline is empty and rows.valid is low
// stall: while a row beat waits with rows.ready low, or is not the last, the
//   whole pipeline holds and camera.ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_top_assert.svh"

module look_at_view_matrix_top #(
	parameter int FRAC_BITS   = lavm_pkg::FRAC_BITS_DEF,
	parameter int COORD_WIDTH = lavm_pkg::COORD_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lavm_in_if.sink     camera,
	lavm_out_if.source  rows
);
	import lavm_pkg::*;

	localparam int C   = COORD_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int BW  = C + 1;
	localparam int NW  = F + 2;
	localparam int RCW = C + 3;
	localparam int TW  = F + 5;
	localparam int XW1 = C + NW;
	localparam int XW2 = 2 * NW;
	localparam int PW  = TW + C;
	localparam int TRW = PW - F + 3;
	localparam int S1W = 1 + 6 * C;
	localparam int S2W = 1 + 3 * NW + 3 * C;

	logic adv;
	logic last;

	// s1: back direction before normalising
	logic              v_s1, deg_s1;
	logic [2:0][C-1:0] p_s1, u_s1;
	logic [2:0][BW-1:0] bk_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= camera.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1     <= {camera.pos_z, camera.pos_y, camera.pos_x};
			u_s1     <= {camera.upward_z, camera.upward_y, camera.upward_x};
			bk_s1[0] <= BW'(camera.pos_x) - BW'(camera.target_x);
			bk_s1[1] <= BW'(camera.pos_y) - BW'(camera.target_y);
			bk_s1[2] <= BW'(camera.pos_z) - BW'(camera.target_z);
			deg_s1   <= camera.pos_x == camera.target_x &&
			            camera.pos_y == camera.target_y &&
			            camera.pos_z == camera.target_z;
		end
	end

	// back = normalise(pos - target)
	logic               v_n1, deg_n1;
	logic [2:0][NW-1:0] bn_n1;
	logic [2:0][C-1:0]  p_n1, u_n1;
	logic [S1W-1:0]     side_n1;

	lavm_norm #(
		.VW     (BW),
		.FRAC   (F),
		.SIDE_W (S1W)
	) u_norm_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s1),
		.vec_in    (bk_s1),
		.in_side   ({deg_s1, u_s1, p_s1}),
		.out_valid (v_n1),
		.vec_out   (bn_n1),
		.out_side  (side_n1)
	);

	assign {deg_n1, u_n1, p_n1} = side_n1;

	// s2, s3: right before normalising = up x back
	logic                v_s2, v_s3, deg_s2, deg_s3;
	logic [5:0][XW1-1:0] xp_s2;
	logic [2:0][NW-1:0]  bn_s2, bn_s3;
	logic [2:0][C-1:0]   p_s2, p_s3;
	logic [2:0][RCW-1:0] rc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_n1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s2[0] <= XW1'(signed'(u_n1[1])) * XW1'(signed'(bn_n1[2]));
			xp_s2[1] <= XW1'(signed'(u_n1[2])) * XW1'(signed'(bn_n1[1]));
			xp_s2[2] <= XW1'(signed'(u_n1[2])) * XW1'(signed'(bn_n1[0]));
			xp_s2[3] <= XW1'(signed'(u_n1[0])) * XW1'(signed'(bn_n1[2]));
			xp_s2[4] <= XW1'(signed'(u_n1[0])) * XW1'(signed'(bn_n1[1]));
			xp_s2[5] <= XW1'(signed'(u_n1[1])) * XW1'(signed'(bn_n1[0]));
			bn_s2    <= bn_n1;
			p_s2     <= p_n1;
			deg_s2   <= deg_n1;
			for (int i = 0; i < 3; i++) begin
				rc_s3[i] <= RCW'(signed'(xp_s2[2*i]) >>> F) -
				            RCW'(signed'(xp_s2[2*i+1]) >>> F);
			end
			bn_s3    <= bn_s2;
			p_s3     <= p_s2;
			deg_s3   <= deg_s2;
		end
	end

	// right = normalise(up x back)
	logic               v_n2, deg_n2;
	logic [2:0][NW-1:0] rn_n2, bn_n2;
	logic [2:0][C-1:0]  p_n2;
	logic [S2W-1:0]     side_n2;

	lavm_norm #(
		.VW     (RCW),
		.FRAC   (F),
		.SIDE_W (S2W)
	) u_norm_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.vec_in    (rc_s3),
		.in_side   ({deg_s3, bn_s3, p_s3}),
		.out_valid (v_n2),
		.vec_out   (rn_n2),
		.out_side  (side_n2)
	);

	assign {deg_n2, bn_n2, p_n2} = side_n2;

	// s4, s5: true up = back x right
	logic                v_s4, v_s5, deg_s4, deg_s5;
	logic [5:0][XW2-1:0] xq_s4;
	logic [2:0][NW-1:0]  bn_s4, rn_s4, bn_s5, rn_s5;
	logic [2:0][C-1:0]   p_s4, p_s5;
	logic [2:0][TW-1:0]  tu_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_n2;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xq_s4[0] <= XW2'(signed'(bn_n2[1])) * XW2'(signed'(rn_n2[2]));
			xq_s4[1] <= XW2'(signed'(bn_n2[2])) * XW2'(signed'(rn_n2[1]));
			xq_s4[2] <= XW2'(signed'(bn_n2[2])) * XW2'(signed'(rn_n2[0]));
			xq_s4[3] <= XW2'(signed'(bn_n2[0])) * XW2'(signed'(rn_n2[2]));
			xq_s4[4] <= XW2'(signed'(bn_n2[0])) * XW2'(signed'(rn_n2[1]));
			xq_s4[5] <= XW2'(signed'(bn_n2[1])) * XW2'(signed'(rn_n2[0]));
			bn_s4    <= bn_n2;
			rn_s4    <= rn_n2;
			p_s4     <= p_n2;
			deg_s4   <= deg_n2;
			for (int i = 0; i < 3; i++) begin
				tu_s5[i] <= TW'(signed'(xq_s4[2*i]) >>> F) -
				            TW'(signed'(xq_s4[2*i+1]) >>> F);
			end
			bn_s5    <= bn_s4;
			rn_s5    <= rn_s4;
			p_s5     <= p_s4;
			deg_s5   <= deg_s4;
		end
	end

	// s6..s8: translations, minus row . pos, saturated
	logic                     v_s6, v_s7, v_s8, deg_s6, deg_s7, deg_s8;
	logic [2:0][2:0][TW-1:0]  r_s5, r_s6, r_s7;
	logic [2:0][2:0][PW-1:0]  tp_s6;
	logic [2:0][TRW-1:0]      tr_s7;
	logic [2:0][2:0][C-1:0]   col_s8;
	logic [2:0][C-1:0]        trn_s8;
	logic signed [TRW-1:0]    sat_hi, sat_lo;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_s5[ROW_RIGHT][i] = TW'(signed'(rn_s5[i]));
			r_s5[ROW_UP][i]    = tu_s5[i];
			r_s5[ROW_BACK][i]  = TW'(signed'(bn_s5[i]));
		end
	end

	assign sat_hi = TRW'(signed'({1'b0, {(C-1){1'b1}}}));
	assign sat_lo = TRW'(signed'({1'b1, {(C-1){1'b0}}}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					tp_s6[k][i]  <= PW'(signed'(r_s5[k][i])) * PW'(signed'(p_s5[i]));
					col_s8[k][i] <= C'(signed'(r_s7[k][i]));
				end
				tr_s7[k] <= -(TRW'(signed'(tp_s6[k][0]) >>> F) +
				              TRW'(signed'(tp_s6[k][1]) >>> F) +
				              TRW'(signed'(tp_s6[k][2]) >>> F));
				if (signed'(tr_s7[k]) > sat_hi) begin
					trn_s8[k] <= C'(sat_hi);
				end else if (signed'(tr_s7[k]) < sat_lo) begin
					trn_s8[k] <= C'(sat_lo);
				end else begin
					trn_s8[k] <= C'(tr_s7[k]);
				end
			end
			r_s6   <= r_s5;
			r_s7   <= r_s6;
			deg_s6 <= deg_s5;
			deg_s7 <= deg_s6;
			deg_s8 <= deg_s7;
		end
	end

	// row sequencer over the held s8 item
	row_t row_q, row_d;

	assign last = deg_s8 || row_q == ROW_BACK;
	assign adv  = !v_s8 || (rows.ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= ROW_RIGHT;
		end else begin
			row_q <= row_d;
		end
	end

	always_comb begin
		row_d = row_q;
		if (v_s8 && rows.ready) begin
			if (last) begin
				row_d = ROW_RIGHT;
			end else begin
				case (row_q)
					ROW_RIGHT: row_d = ROW_UP;
					ROW_UP:    row_d = ROW_BACK;
					default:   row_d = ROW_RIGHT;
				endcase
			end
		end
	end

	always_comb begin
		rows.row_index = row_q;
		rows.col_zero  = '0;
		rows.col_one   = '0;
		rows.col_two   = '0;
		rows.col_three = '0;
		case (row_q)
			ROW_RIGHT: begin
				rows.col_zero  = col_s8[ROW_RIGHT][0];
				rows.col_one   = col_s8[ROW_RIGHT][1];
				rows.col_two   = col_s8[ROW_RIGHT][2];
				rows.col_three = trn_s8[ROW_RIGHT];
			end
			ROW_UP: begin
				rows.col_zero  = col_s8[ROW_UP][0];
				rows.col_one   = col_s8[ROW_UP][1];
				rows.col_two   = col_s8[ROW_UP][2];
				rows.col_three = trn_s8[ROW_UP];
			end
			ROW_BACK: begin
				rows.col_zero  = col_s8[ROW_BACK][0];
				rows.col_one   = col_s8[ROW_BACK][1];
				rows.col_two   = col_s8[ROW_BACK][2];
				rows.col_three = trn_s8[ROW_BACK];
			end
			default: begin
				rows.row_index = ROW_RIGHT;
			end
		endcase
		// degenerate beat carries no matrix
		if (deg_s8) begin
			rows.row_index = ROW_RIGHT;
			rows.col_zero  = '0;
			rows.col_one   = '0;
			rows.col_two   = '0;
			rows.col_three = '0;
		end
	end

	assign rows.valid      = v_s8;
	assign rows.last_row   = last;
	assign rows.degenerate = deg_s8;
	assign camera.ready    = adv;

	`LAVM_ASSERT_NEXT(a_row_hold, rows.valid && !rows.ready, rows.valid && $stable(row_q), "row beat changed while stalled")
	`LAVM_ASSERT_NEXT(a_row_more, rows.valid && rows.ready && !rows.last_row, rows.valid, "rows of an item ended early")
	`LAVM_ASSERT_NEXT(a_row_restart, rows.valid && rows.ready && rows.last_row, row_q == ROW_RIGHT, "next item does not start at row zero")
	`LAVM_ASSERT_NOW(a_take_busy, camera.ready && v_s8, rows.ready && rows.last_row, "camera taken while rows pending")

endmodule
